// ----- rtl/irpfr_pkg.sv -----
// Package for the IR preamble frame receiver.
// Holds constants, codes and the classified transaction type shared by all modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irpfr_pkg;

    localparam int WORD_BITS = 8;
    localparam int BITPOS_W  = $clog2(WORD_BITS + 1);
    localparam int DUR_W     = 16;
    localparam int HOLD_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WORD_BITS-1:0] word_t;

    // event kinds
    localparam logic [1:0] EV_RISE = 2'd0;
    localparam logic [1:0] EV_FALL = 2'd1;
    localparam logic [1:0] EV_TICK = 2'd2;
    localparam logic [1:0] EV_NONE = 2'd3;

    // frame status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFRAME_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_HOLD_RESETS = 3'd6;

    // classified transaction passed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic       start_ok;
        logic       pulse_ok;
        logic       gap_ok;
        logic       one;
    } irpfr_event_t;

endpackage

`default_nettype wire

// ----- rtl/irpfr_if.sv -----
// Channel interfaces of the IR preamble frame receiver: event input and result output.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface irpfr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] duration;
    logic        line_level;

    modport source (output valid, output req_type, output duration, output line_level,
                    input ready);
    modport sink (input valid, input req_type, input duration, input line_level,
                  output ready);
endinterface

interface irpfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    logic [7:0] beamer_id;
    logic [7:0] angle_code;
    logic       led_on;

    modport source (output valid, output frame_status, output beamer_id,
                    output angle_code, output led_on, input ready);
    modport sink (input valid, input frame_status, input beamer_id,
                  input angle_code, input led_on, output ready);
endinterface

`default_nettype wire

// ----- rtl/irpfr_front.sv -----
// Front end: configuration registers and event classification against the windows.
// Depends on irpfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpfr_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [irpfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [irpfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [1:0]                        req_type,
    input  wire logic [irpfr_pkg::DUR_W-1:0]       duration,
    input  wire logic                              line_level,
    output irpfr_pkg::irpfr_event_t                ev,
    output logic [irpfr_pkg::HOLD_W-1:0]           led_hold
);
    import irpfr_pkg::*;

    logic [DUR_W-1:0]  interframe_min_reg;
    logic [DUR_W-1:0]  pulse_min_reg;
    logic [DUR_W-1:0]  pulse_max_reg;
    logic [DUR_W-1:0]  gap_min_reg;
    logic [DUR_W-1:0]  gap_max_reg;
    logic              active_high_reg;
    logic [HOLD_W-1:0] led_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interframe_min_reg <= '0;
            pulse_min_reg      <= '0;
            pulse_max_reg      <= '1;
            gap_min_reg        <= '0;
            gap_max_reg        <= '1;
            active_high_reg    <= 1'b1;
            led_hold_reg       <= HOLD_W'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERFRAME_MIN:  interframe_min_reg <= cfg_data[DUR_W-1:0];
                CFG_PULSE_MIN:       pulse_min_reg      <= cfg_data[DUR_W-1:0];
                CFG_PULSE_MAX:       pulse_max_reg      <= cfg_data[DUR_W-1:0];
                CFG_GAP_MIN:         gap_min_reg        <= cfg_data[DUR_W-1:0];
                CFG_GAP_MAX:         gap_max_reg        <= cfg_data[DUR_W-1:0];
                CFG_ACTIVE_HIGH:     active_high_reg    <= cfg_data[0];
                CFG_LED_HOLD_RESETS: led_hold_reg       <= cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ev.kind     = req_type;
        ev.start_ok = duration > interframe_min_reg;
        ev.pulse_ok = (duration > pulse_min_reg) && (duration < pulse_max_reg);
        ev.gap_ok   = (duration > gap_min_reg) && (duration < gap_max_reg);
        ev.one      = line_level == active_high_reg;
    end

    assign led_hold = led_hold_reg;

endmodule

`default_nettype wire

// ----- rtl/irpfr_queue.sv -----
// Two-entry queue of classified events between front and back.
// Depends on irpfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpfr_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire irpfr_pkg::irpfr_event_t push_data,
    input  wire logic                    pop,
    output irpfr_pkg::irpfr_event_t      head,
    output logic                         not_empty,
    output logic                         full
);
    import irpfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    irpfr_event_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/irpfr_back.sv -----
// Back end: packet sequencer, word assembly, inverse check, LED logic, result register.
// Depends on irpfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpfr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire irpfr_pkg::irpfr_event_t       ev,
    input  wire logic                          ev_valid,
    output logic                               ev_pop,
    input  wire logic [irpfr_pkg::HOLD_W-1:0]  led_hold,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         frame_status,
    output logic [7:0]                         beamer_id,
    output logic [7:0]                         angle_code,
    output logic                               led_on
);
    import irpfr_pkg::*;

    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_PRE   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    localparam logic [2:0] SS_PULSE1 = 3'd0;
    localparam logic [2:0] SS_GAP1   = 3'd1;
    localparam logic [2:0] SS_PULSE2 = 3'd2;
    localparam logic [2:0] SS_GAP2   = 3'd3;
    localparam logic [2:0] SS_TSTART = 3'd4;

    localparam word_t WORD_MSB = word_t'(1) << (WORD_BITS - 1);

    logic [1:0]          phase_reg, phase_next;
    logic [2:0]          sub_reg, sub_next;
    logic [1:0]          widx_reg, widx_next;
    logic [BITPOS_W-1:0] bitpos_reg, bitpos_next;
    word_t               word0_reg, word0_next;
    word_t               word1_reg, word1_next;
    word_t               word2_reg, word2_next;
    logic [HOLD_W-1:0]   rcount_reg, rcount_next;
    logic                led_reg, led_next;

    logic                out_valid_reg;
    logic [1:0]          status_reg, status_next;
    logic [7:0]          id_reg, id_next;
    logic [7:0]          ang_reg, ang_next;

    logic                do_reset;
    logic                success;
    logic [HOLD_W-1:0]   cnt_base;
    logic                led_base;
    logic [HOLD_W:0]     cnt_inc;
    word_t               set_mask;
    logic [BITPOS_W-1:0] bitpos_inc;

    assign ev_pop   = ev_valid && (!out_valid_reg || out_ready);
    assign set_mask = ev.one ? (WORD_MSB >> bitpos_reg) : '0;
    assign bitpos_inc = bitpos_reg + BITPOS_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        widx_next   = widx_reg;
        bitpos_next = bitpos_reg;
        word0_next  = word0_reg;
        word1_next  = word1_reg;
        word2_next  = word2_reg;
        rcount_next = rcount_reg;
        led_next    = led_reg;
        status_next = ST_NONE;
        id_next     = '0;
        ang_next    = '0;
        do_reset    = 1'b0;
        success     = 1'b0;
        cnt_base    = rcount_reg;
        led_base    = led_reg;
        cnt_inc     = '0;

        if (ev.kind != EV_NONE)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (ev.kind == EV_RISE && ev.start_ok)
                    begin
                        phase_next = PH_PRE;
                        sub_next   = SS_PULSE1;
                    end
                end
                PH_PRE:
                begin
                    case (sub_reg)
                        SS_PULSE1, SS_PULSE2:
                        begin
                            if (ev.kind == EV_FALL && ev.pulse_ok)
                                sub_next = (sub_reg == SS_PULSE1) ? SS_GAP1 : SS_GAP2;
                            else
                                do_reset = 1'b1;
                        end
                        SS_GAP1:
                        begin
                            if (ev.kind == EV_RISE && ev.gap_ok)
                                sub_next = SS_PULSE2;
                            else
                                do_reset = 1'b1;
                        end
                        SS_GAP2:
                        begin
                            if (ev.kind == EV_TICK)
                            begin
                                sub_next    = SS_PULSE1;
                                phase_next  = PH_DATA;
                                widx_next   = '0;
                                word0_next  = '0;
                                word1_next  = '0;
                                word2_next  = '0;
                                bitpos_next = '0;
                            end
                        end
                        default: do_reset = 1'b1;
                    endcase
                end
                PH_DATA:
                begin
                    if (ev.kind == EV_TICK)
                    begin
                        if (widx_reg == 2'd3)
                            do_reset = 1'b1;
                        else if (bitpos_reg < BITPOS_W'(WORD_BITS))
                        begin
                            case (widx_reg)
                                2'd0:    word0_next = word0_reg | set_mask;
                                2'd1:    word1_next = word1_reg | set_mask;
                                default: word2_next = word2_reg | set_mask;
                            endcase
                            bitpos_next = bitpos_inc;
                            if (widx_reg == 2'd2 && bitpos_inc == BITPOS_W'(WORD_BITS))
                            begin
                                bitpos_next = '0;
                                phase_next  = PH_TRAIL;
                                sub_next    = SS_TSTART;
                            end
                        end
                        else
                        begin
                            widx_next   = widx_reg + 2'd1;
                            bitpos_next = '0;
                        end
                    end
                end
                default:
                begin
                    case (sub_reg)
                        SS_TSTART:
                        begin
                            if (ev.kind == EV_TICK)
                                sub_next = SS_GAP1;
                        end
                        SS_GAP1:
                        begin
                            if (ev.kind == EV_RISE && ev.gap_ok)
                                sub_next = SS_PULSE1;
                        end
                        SS_PULSE1:
                        begin
                            if (ev.kind == EV_FALL && ev.pulse_ok)
                            begin
                                if (word1_reg == ~word2_reg)
                                begin
                                    success     = 1'b1;
                                    status_next = ST_OK;
                                    id_next     = 8'(word0_reg);
                                    ang_next    = 8'(word1_reg);
                                end
                                else
                                    status_next = ST_FAIL;
                            end
                            do_reset = 1'b1;
                        end
                        default: do_reset = 1'b1;
                    endcase
                end
            endcase
        end

        if (do_reset)
        begin
            cnt_base   = success ? '0 : rcount_reg;
            led_base   = success ? 1'b1 : led_reg;
            cnt_inc    = {1'b0, cnt_base} + (HOLD_W+1)'(1);
            led_next   = led_base;
            if (cnt_inc > {1'b0, led_hold})
            begin
                cnt_inc  = {1'b0, led_hold} + (HOLD_W+1)'(1);
                led_next = 1'b0;
            end
            if (cnt_inc > (HOLD_W+1)'(31))
                cnt_inc = (HOLD_W+1)'(31);
            rcount_next = cnt_inc[HOLD_W-1:0];
            phase_next  = PH_WAIT;
            widx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            sub_reg       <= SS_PULSE1;
            widx_reg      <= '0;
            bitpos_reg    <= '0;
            word0_reg     <= '0;
            word1_reg     <= '0;
            word2_reg     <= '0;
            rcount_reg    <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_pop)
            begin
                phase_reg     <= phase_next;
                sub_reg       <= sub_next;
                widx_reg      <= widx_next;
                bitpos_reg    <= bitpos_next;
                word0_reg     <= word0_next;
                word1_reg     <= word1_next;
                word2_reg     <= word2_next;
                rcount_reg    <= rcount_next;
                led_reg       <= led_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            ang_reg    <= ang_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign beamer_id    = id_reg;
    assign angle_code   = ang_reg;
    assign led_on       = led_reg;

    a_led_rise_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(led_reg) |-> out_valid_reg && status_reg == ST_OK)
        else $error("LED turned on without an accepted frame");
    a_status_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_NONE |-> phase_reg == PH_WAIT)
        else $error("frame result without sequence restart");
    a_words_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> id_reg == '0 && ang_reg == '0)
        else $error("words shown without accepted frame");

endmodule

`default_nettype wire

// ----- rtl/ir_preamble_frame_receiver_unit.sv -----
// Top level of the IR preamble frame receiver.
// Depends on irpfr_pkg, irpfr_if, irpfr_front, irpfr_queue, irpfr_back.
//
// channel   dir  handshake      payload
// in_ch     in   valid/ready    req_type, duration, line_level
// out_ch    out  valid/ready    frame_status, beamer_id, angle_code, led_on
// cfg       in   cfg_we         cfg_index, cfg_data
//
// One result per event; one event per cycle sustained while out_ch.ready is high.
// An event is queued, then its result registered; the back-end sequencer sets the rate.
// A two-entry queue parts front and back; in_ch.ready drops only when it is full.
// A result waits in the output register while later events queue up.
// Reset is asynchronous, active low, and sets control and config state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ir_preamble_frame_receiver_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [irpfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [irpfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    irpfr_in_if.sink                               in_ch,
    irpfr_out_if.source                            out_ch
);
    import irpfr_pkg::*;

    irpfr_event_t      front_ev;
    irpfr_event_t      queue_head;
    logic [HOLD_W-1:0] led_hold;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic              q_push;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    irpfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (in_ch.req_type),
        .duration   (in_ch.duration),
        .line_level (in_ch.line_level),
        .ev         (front_ev),
        .led_hold   (led_hold)
    );

    irpfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_ev),
        .pop       (q_pop),
        .head      (queue_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    irpfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev           (queue_head),
        .ev_valid     (q_not_empty),
        .ev_pop       (q_pop),
        .led_hold     (led_hold),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .frame_status (out_ch.frame_status),
        .beamer_id    (out_ch.beamer_id),
        .angle_code   (out_ch.angle_code),
        .led_on       (out_ch.led_on)
    );

endmodule

`default_nettype wire
